// ===== design/bcr_pkg.sv =====
// Shared types, widths and constants for the blob centroid and radius block.
// Used by every module of the block; depends on nothing.
package bcr_pkg;

    localparam int MAX_ROWS = 2048;
    localparam int MAX_COLS = 2048;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 11;
    localparam int CNT_W     = 23;
    localparam int SUM_W     = 34;
    localparam int SPAN_W    = POS_W + 1;
    localparam int RAD_W     = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam int DIV_STEPS = POS_W;
    localparam int STEP_W    = 4;

    localparam logic [PIX_W-1:0] FG_LEVEL = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_ROWS_RESET = 12'd480;
    localparam logic [CFG_W-1:0] FRAME_COLS_RESET = 12'd640;
    localparam logic [CFG_W-1:0] MAX_ROWS_C       = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] MAX_COLS_C       = CFG_W'(MAX_COLS);

    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
        logic [CNT_W-1:0] area_count;
        logic [POS_W-1:0] top_row;
        logic [POS_W-1:0] bottom_row;
        logic [POS_W-1:0] left_col;
        logic [POS_W-1:0] right_col;
    } frame_rec_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/bcr_front.sv =====
// Front end: holds the frame size registers, counts row and column, and
// accumulates foreground statistics. Pushes one frame record per frame; uses bcr_pkg.
module bcr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bcr_pkg::PIX_W-1:0]     s_pixel,
    output logic                          rec_valid,
    input  logic                          rec_ready,
    output bcr_pkg::frame_rec_t           rec_data
);
    import bcr_pkg::*;

    logic [CFG_W-1:0] frame_rows_reg;
    logic [CFG_W-1:0] frame_cols_reg;
    logic [POS_W-1:0] row_pos_reg;
    logic [POS_W-1:0] col_pos_reg;
    logic [CNT_W-1:0] area_count_reg;
    logic [SUM_W-1:0] row_sum_reg;
    logic [SUM_W-1:0] col_sum_reg;
    logic [POS_W-1:0] top_row_reg;
    logic [POS_W-1:0] bottom_row_reg;
    logic [POS_W-1:0] left_col_reg;
    logic [POS_W-1:0] right_col_reg;

    logic [CNT_W-1:0] area_count_next;
    logic [SUM_W-1:0] row_sum_next;
    logic [SUM_W-1:0] col_sum_next;
    logic [POS_W-1:0] top_row_next;
    logic [POS_W-1:0] bottom_row_next;
    logic [POS_W-1:0] left_col_next;
    logic [POS_W-1:0] right_col_next;

    logic [CFG_W-1:0] rows_last;
    logic [CFG_W-1:0] cols_last;
    logic             fg;
    logic             last_col;
    logic             last_row;
    logic             accept;
    logic             cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS);

    assign rows_last = clamp_size(frame_rows_reg, MAX_ROWS_C) - CFG_W'(1);
    assign cols_last = clamp_size(frame_cols_reg, MAX_COLS_C) - CFG_W'(1);
    assign last_col  = ({1'b0, col_pos_reg} == cols_last);
    assign last_row  = ({1'b0, row_pos_reg} == rows_last);

    assign fg      = (s_pixel == FG_LEVEL);
    assign s_ready = rec_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        area_count_next = area_count_reg;
        row_sum_next    = row_sum_reg;
        col_sum_next    = col_sum_reg;
        top_row_next    = top_row_reg;
        bottom_row_next = bottom_row_reg;
        left_col_next   = left_col_reg;
        right_col_next  = right_col_reg;
        if (fg) begin
            area_count_next = area_count_reg + CNT_W'(1);
            row_sum_next    = row_sum_reg + SUM_W'(row_pos_reg);
            col_sum_next    = col_sum_reg + SUM_W'(col_pos_reg);
            if (row_pos_reg < top_row_reg) begin
                top_row_next = row_pos_reg;
            end
            if (row_pos_reg > bottom_row_reg) begin
                bottom_row_next = row_pos_reg;
            end
            if (col_pos_reg < left_col_reg) begin
                left_col_next = col_pos_reg;
            end
            if (col_pos_reg > right_col_reg) begin
                right_col_next = col_pos_reg;
            end
        end
    end

    assign rec_valid           = s_valid && last_col && last_row;
    assign rec_data.row_sum    = row_sum_next;
    assign rec_data.col_sum    = col_sum_next;
    assign rec_data.area_count = area_count_next;
    assign rec_data.top_row    = top_row_next;
    assign rec_data.bottom_row = bottom_row_next;
    assign rec_data.left_col   = left_col_next;
    assign rec_data.right_col  = right_col_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write || (accept && last_col && last_row)) begin
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            area_count_reg <= '0;
            row_sum_reg    <= '0;
            col_sum_reg    <= '0;
            top_row_reg    <= '1;
            bottom_row_reg <= '0;
            left_col_reg   <= '1;
            right_col_reg  <= '0;
        end else if (accept) begin
            area_count_reg <= area_count_next;
            row_sum_reg    <= row_sum_next;
            col_sum_reg    <= col_sum_next;
            top_row_reg    <= top_row_next;
            bottom_row_reg <= bottom_row_next;
            left_col_reg   <= left_col_next;
            right_col_reg  <= right_col_next;
            if (last_col) begin
                col_pos_reg <= '0;
                row_pos_reg <= row_pos_reg + POS_W'(1);
            end else begin
                col_pos_reg <= col_pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= FRAME_ROWS_RESET;
            frame_cols_reg <= FRAME_COLS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_ROWS) begin
                frame_rows_reg <= cfg_data;
            end
            if (cfg_index == REG_FRAME_COLS) begin
                frame_cols_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== design/bcr_fifo.sv =====
// Short queue of frame records between the front end and the divider back end.
// Uses bcr_pkg for the record type and depth.
module bcr_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  bcr_pkg::frame_rec_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bcr_pkg::frame_rec_t out_data
);
    import bcr_pkg::*;

    frame_rec_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QUEUE_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QUEUE_CW'(1);
            end
        end
    end

endmodule

// ===== design/bcr_back.sv =====
// Back end: takes frame records, divides both sums by the count one quotient
// bit per cycle, computes the radius and holds the result word. Uses bcr_pkg.
module bcr_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rec_valid,
    output logic                      rec_ready,
    input  bcr_pkg::frame_rec_t       rec_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [bcr_pkg::POS_W-1:0] m_row_centroid,
    output logic [bcr_pkg::POS_W-1:0] m_col_centroid,
    output logic [bcr_pkg::RAD_W-1:0] m_radius,
    output logic [bcr_pkg::CNT_W-1:0] m_pixel_count,
    output logic                      m_empty_res
);
    import bcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t       state_reg;
    logic [SUM_W-1:0]  row_rem_reg;
    logic [SUM_W-1:0]  col_rem_reg;
    logic [SUM_W-1:0]  divisor_reg;
    logic [POS_W-1:0]  row_quo_reg;
    logic [POS_W-1:0]  col_quo_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic              empty_reg;
    logic [STEP_W-1:0] step_reg;

    logic              m_valid_reg;
    logic [POS_W-1:0]  m_row_centroid_reg;
    logic [POS_W-1:0]  m_col_centroid_reg;
    logic [RAD_W-1:0]  m_radius_reg;
    logic [CNT_W-1:0]  m_pixel_count_reg;
    logic              m_empty_res_reg;

    logic [SPAN_W-1:0] span;
    logic              row_ge;
    logic              col_ge;
    logic              out_free;

    assign span = SPAN_W'(rec_data.bottom_row - rec_data.top_row)
                + SPAN_W'(rec_data.right_col - rec_data.left_col);

    assign row_ge    = (row_rem_reg >= divisor_reg);
    assign col_ge    = (col_rem_reg >= divisor_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign rec_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (rec_valid) begin
                        state_reg <= (rec_data.area_count == '0) ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (step_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                row_rem_reg <= rec_data.row_sum;
                col_rem_reg <= rec_data.col_sum;
                divisor_reg <= SUM_W'(rec_data.area_count) << (DIV_STEPS - 1);
                row_quo_reg <= '0;
                col_quo_reg <= '0;
                count_reg   <= rec_data.area_count;
                step_reg    <= STEP_W'(DIV_STEPS - 1);
                empty_reg   <= (rec_data.area_count == '0);
                radius_reg  <= (rec_data.area_count == '0) ? '0 : span[SPAN_W-1:2];
            end
            ST_DIV: begin
                if (row_ge) begin
                    row_rem_reg <= row_rem_reg - divisor_reg;
                end
                if (col_ge) begin
                    col_rem_reg <= col_rem_reg - divisor_reg;
                end
                row_quo_reg <= {row_quo_reg[POS_W-2:0], row_ge};
                col_quo_reg <= {col_quo_reg[POS_W-2:0], col_ge};
                divisor_reg <= divisor_reg >> 1;
                step_reg    <= step_reg - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_row_centroid_reg <= row_quo_reg;
            m_col_centroid_reg <= col_quo_reg;
            m_radius_reg       <= radius_reg;
            m_pixel_count_reg  <= count_reg;
            m_empty_res_reg    <= empty_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_row_centroid = m_row_centroid_reg;
    assign m_col_centroid = m_col_centroid_reg;
    assign m_radius       = m_radius_reg;
    assign m_pixel_count  = m_pixel_count_reg;
    assign m_empty_res    = m_empty_res_reg;

endmodule

// ===== design/blob_centroid_and_radius.sv =====
// Blob centroid and radius, top level: front end, record queue and divider back end.
// Pixels are taken one per cycle; the queue stalls pixel input only when it is full.
// A record leaves the queue for the divide state, or for the done state if empty;
// the shared 11-step divider takes no new record until the last result is registered.
// Reset is synchronous and active low and restores 480 rows by 640 columns.
// Depends on bcr_pkg, bcr_front, bcr_fifo and bcr_back.
module blob_centroid_and_radius (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcr_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bcr_pkg::PIX_W-1:0]     s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bcr_pkg::POS_W-1:0]     m_row_centroid,
    output logic [bcr_pkg::POS_W-1:0]     m_col_centroid,
    output logic [bcr_pkg::RAD_W-1:0]     m_radius,
    output logic [bcr_pkg::CNT_W-1:0]     m_pixel_count,
    output logic                          m_empty_res
);
    import bcr_pkg::*;

    logic       push_valid;
    logic       push_ready;
    frame_rec_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    frame_rec_t pop_data;

    bcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .rec_valid (push_valid),
        .rec_ready (push_ready),
        .rec_data  (push_data)
    );

    bcr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    bcr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rec_valid      (pop_valid),
        .rec_ready      (pop_ready),
        .rec_data       (pop_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_centroid (m_row_centroid),
        .m_col_centroid (m_col_centroid),
        .m_radius       (m_radius),
        .m_pixel_count  (m_pixel_count),
        .m_empty_res    (m_empty_res)
    );

`ifndef SYNTHESIS
    a_empty_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_empty_res) |-> (m_pixel_count == '0 && m_radius == '0 &&
                                      m_row_centroid == '0 && m_col_centroid == '0))
        else $error("empty result word carries nonzero fields");

    a_nonempty_has_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_empty_res) |-> (m_pixel_count != '0))
        else $error("nonempty result word has zero pixel count");

    a_queue_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && pop_ready) |=> !pop_ready)
        else $error("back end took a second record while still dividing");
`endif

endmodule

// ===== tb/sv/blob_centroid_and_radius_tb.sv =====
// Self-checking testbench for blob_centroid_and_radius: raster frames of many sizes and
// foreground patterns, checked word by word against a scoreboard that predicts each result.
// Depends on bcr_pkg and the blob_centroid_and_radius RTL.
module blob_centroid_and_radius_tb;
    import bcr_pkg::*;

    localparam int RANDOM_ITEMS  = 1025;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int QUARTER_SHIFT = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum int {
        PAT_EMPTY, PAT_SPARSE, PAT_HALF, PAT_DENSE, PAT_FULL, PAT_ENDS, PAT_LAST
    } frame_pattern_e;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [POS_W-1:0] row_centroid;
        logic [POS_W-1:0] col_centroid;
        logic [RAD_W-1:0] radius;
        logic [CNT_W-1:0] pixel_count;
        logic             empty_res;
    } blob_result_t;

    class blob_scoreboard;
        logic [CFG_W-1:0] rows_reg = FRAME_ROWS_RESET;
        logic [CFG_W-1:0] cols_reg = FRAME_COLS_RESET;
        logic [POS_W:0]   row_pos;
        logic [POS_W:0]   col_pos;
        logic [CNT_W-1:0] area;
        logic [SUM_W-1:0] row_total;
        logic [SUM_W-1:0] col_total;
        logic [POS_W-1:0] top_row;
        logic [POS_W-1:0] bottom_row;
        logic [POS_W-1:0] left_col;
        logic [POS_W-1:0] right_col;
        blob_result_t     expected_blobs[$];
        int               errors;

        function new();
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            row_pos    = '0;
            col_pos    = '0;
            area       = '0;
            row_total  = '0;
            col_total  = '0;
            top_row    = '1;
            bottom_row = '0;
            left_col   = '1;
            right_col  = '0;
        endfunction

        static function int clip_extent(logic [CFG_W-1:0] v, int limit);
            if (v == '0) begin
                return 1;
            end
            if (int'(v) > limit) begin
                return limit;
            end
            return int'(v);
        endfunction

        function int frame_height();
            return clip_extent(rows_reg, MAX_ROWS);
        endfunction

        function int frame_width();
            return clip_extent(cols_reg, MAX_COLS);
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_FRAME_ROWS) begin
                rows_reg = data;
                restart_frame();
            end else if (idx == REG_FRAME_COLS) begin
                cols_reg = data;
                restart_frame();
            end
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            blob_result_t     blob;
            logic [SUM_W-1:0] quotient;
            logic [POS_W:0]   span;
            if (pix == FG_LEVEL) begin
                if (row_pos[POS_W-1:0] < top_row) begin
                    top_row = row_pos[POS_W-1:0];
                end
                if (row_pos[POS_W-1:0] > bottom_row) begin
                    bottom_row = row_pos[POS_W-1:0];
                end
                if (col_pos[POS_W-1:0] < left_col) begin
                    left_col = col_pos[POS_W-1:0];
                end
                if (col_pos[POS_W-1:0] > right_col) begin
                    right_col = col_pos[POS_W-1:0];
                end
                area++;
                row_total += SUM_W'(row_pos);
                col_total += SUM_W'(col_pos);
            end
            col_pos++;
            if (col_pos >= frame_width()) begin
                col_pos = '0;
                row_pos++;
                if (row_pos >= frame_height()) begin
                    blob = '0;
                    if (area == '0) begin
                        blob.empty_res = 1'b1;
                    end else begin
                        quotient          = row_total / SUM_W'(area);
                        blob.row_centroid = quotient[POS_W-1:0];
                        quotient          = col_total / SUM_W'(area);
                        blob.col_centroid = quotient[POS_W-1:0];
                        span = {1'b0, bottom_row - top_row} + {1'b0, right_col - left_col};
                        blob.radius       = RAD_W'(span >> QUARTER_SHIFT);
                        blob.pixel_count  = area;
                    end
                    expected_blobs.push_back(blob);
                    restart_frame();
                end
            end
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(blob_result_t got);
            blob_result_t want;
            if (expected_blobs.size() == 0) begin
                $display("%0t: unexpected result word: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_blobs.pop_front();
            compare_field("row_centroid", want.row_centroid, got.row_centroid);
            compare_field("col_centroid", want.col_centroid, got.col_centroid);
            compare_field("radius", want.radius, got.radius);
            compare_field("pixel_count", want.pixel_count, got.pixel_count);
            compare_field("empty_res", want.empty_res, got.empty_res);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel;
    logic                 m_valid;
    logic                 m_ready;
    logic [POS_W-1:0]     m_row_centroid;
    logic [POS_W-1:0]     m_col_centroid;
    logic [RAD_W-1:0]     m_radius;
    logic [CNT_W-1:0]     m_pixel_count;
    logic                 m_empty_res;

    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             cycle_count;
    blob_scoreboard sb;

    blob_centroid_and_radius i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row_centroid (m_row_centroid),
        .m_col_centroid (m_col_centroid),
        .m_radius       (m_radius),
        .m_pixel_count  (m_pixel_count),
        .m_empty_res    (m_empty_res)
    );

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic void set_idle(idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 64;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 64;
            end
            default: begin
                send_idle_pct  = 18;
                recv_stall_pct = 18;
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] large_extent();
        case ($urandom_range(0, 2))
            0:       return CFG_W'(MAX_ROWS);
            1:       return '1;
            default: return CFG_W'($urandom_range(MAX_ROWS + 1, 4094));
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(frame_pattern_e pattern, int idx, int total);
        bit fg;
        case (pattern)
            PAT_EMPTY:  fg = 1'b0;
            PAT_SPARSE: fg = roll(5);
            PAT_HALF:   fg = roll(50);
            PAT_DENSE:  fg = roll(95);
            PAT_FULL:   fg = 1'b1;
            PAT_ENDS:   fg = (idx == 0) || (idx == total - 1);
            default:    fg = (idx == total - 1);
        endcase
        return fg ? FG_LEVEL : PIX_W'($urandom_range(0, 254));
    endfunction

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] pix);
        @(negedge aclk);
        while (roll(send_idle_pct)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(pix);
    endtask

    task automatic send_frame(frame_pattern_e pattern, int count, int total);
        for (int i = 0; i < count; i++) begin
            send_pixel(pick_pixel(pattern, i, total));
        end
    endtask

    task automatic settle(int extra);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_blobs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (extra) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= !roll(recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_row_centroid, m_col_centroid, m_radius, m_pixel_count,
                             m_empty_res});
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int               random_items;
        int               phase;
        int               frames;
        int               count;
        int               total;
        int               big_phases;
        bit               big;
        logic [CFG_W-1:0] rows_val;
        logic [CFG_W-1:0] cols_val;
        frame_pattern_e   pattern;

        sb        = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_ROWS;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_pixel   = '0;
        set_idle(IDLE_NONE);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // One-pixel frames: every word is a frame of its own, empty or not.
        program_reg(REG_FRAME_ROWS, 12'd1);
        program_reg(REG_FRAME_COLS, 12'd1);
        program_reg(REG_SPARE_2, '1);
        program_reg(REG_SPARE_3, 12'd2048);
        send_pixel(FG_LEVEL);
        send_pixel(8'd0);
        send_pixel(8'd254);
        send_pixel(8'd1);
        send_pixel(8'd128);
        send_pixel(8'd127);
        settle(SETTLE_CYCLES);

        // A size of zero behaves as one.
        program_reg(REG_FRAME_ROWS, '0);
        program_reg(REG_FRAME_COLS, '0);
        send_pixel(FG_LEVEL);
        send_pixel(8'd0);
        settle(SETTLE_CYCLES);

        // Corner pixels, then a partial frame that the next register write abandons.
        program_reg(REG_FRAME_ROWS, 12'd3);
        program_reg(REG_FRAME_COLS, 12'd4);
        send_frame(PAT_ENDS, 12, 12);
        send_frame(PAT_FULL, 5, 12);
        settle(SETTLE_CYCLES);

        random_items = 0;
        phase        = 0;
        big_phases   = 0;
        while (random_items < RANDOM_ITEMS) begin
            set_idle(idle_mode_e'(phase % 4));
            big = (phase == 2) || (phase == 3) || (big_phases < 4 && roll(3));
            if (big) begin
                big_phases++;
                if (phase == 2 || (phase != 3 && roll(50))) begin
                    rows_val = large_extent();
                    cols_val = CFG_W'($urandom_range(0, 1));
                end else begin
                    rows_val = CFG_W'($urandom_range(0, 1));
                    cols_val = large_extent();
                end
            end else begin
                rows_val = roll(10) ? '0 : CFG_W'($urandom_range(1, 6));
                cols_val = roll(10) ? '0 : CFG_W'($urandom_range(1, 8));
            end

            settle(SETTLE_CYCLES);
            if (roll(50)) begin
                program_reg(REG_FRAME_ROWS, rows_val);
                program_reg(REG_FRAME_COLS, cols_val);
            end else begin
                program_reg(REG_FRAME_COLS, cols_val);
                program_reg(REG_FRAME_ROWS, rows_val);
            end
            if (roll(25)) begin
                program_reg(roll(50) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom()));
            end

            total  = sb.frame_height() * sb.frame_width();
            frames = big ? 1 : $urandom_range(2, 8);
            for (int f = 0; f < frames; f++) begin
                if ((phase == 0 && f == 1) || roll(8)) begin
                    settle(0);
                end
                if (phase == 2) begin
                    pattern = PAT_LAST;
                end else if (phase == 3) begin
                    pattern = PAT_ENDS;
                end else begin
                    pattern = frame_pattern_e'($urandom_range(PAT_EMPTY, PAT_LAST));
                end
                if (big) begin
                    // Large frames are only started; the next register write abandons them.
                    count = $urandom_range(64, 160);
                    send_frame(pattern, count, total);
                    random_items += count;
                end else begin
                    send_frame(pattern, total, total);
                    random_items += total;
                end
            end
            if (!big && total > 1 && roll(30)) begin
                count = $urandom_range(1, total - 1);
                send_frame(frame_pattern_e'($urandom_range(PAT_EMPTY, PAT_LAST)), count, total);
                random_items += count;
            end
            phase++;
        end

        settle(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.expected_blobs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
